[rtl/wzfk_pkg.sv]
// package: shared constants, types and the cordic arctangent table
`timescale 1ns / 1ps
`default_nettype none
package wzfk_pkg;

   localparam int ANGLE_BITS_DEFAULT  = 16;
   localparam int LENGTH_BITS_DEFAULT = 16;
   localparam int CORDIC_STEPS        = 16;
   localparam int STEP_BITS           = 4;
   localparam int CORDIC_BITS         = 33;
   localparam int TRIG_BITS           = 18;
   localparam int PHASE_BITS          = 32;
   localparam logic signed [CORDIC_BITS-1:0] CORDIC_START = 33'sd652032874;

   localparam int CSR_INDEX_BITS = 2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_BASE_LINK  = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_YAW_LINK   = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PITCH_LINK = 2'd2;
   localparam int YAW_LINK_RESET = 393;

   typedef enum logic [1:0] {
      STAGE_ROLL  = 2'd0,
      STAGE_PITCH = 2'd1,
      STAGE_YAW   = 2'd2
   } stage_type;

   typedef enum logic [3:0] {
      PH_IDLE, PH_LOAD, PH_ITER, PH_TRIG,
      PH_M0, PH_M1, PH_M2, PH_M3, PH_M4, PH_OUT
   } phase_type;

   typedef struct packed {
      logic                 accept;
      phase_type            phase;
      stage_type            stage;
      logic [STEP_BITS-1:0] step;
   } cmd_type;

   function automatic logic signed [CORDIC_BITS-1:0] atan_phase(
      input logic [STEP_BITS-1:0] idx);
      logic signed [CORDIC_BITS-1:0] r;
      begin
         case (idx)
            4'd0:    r = 33'sd536870912;
            4'd1:    r = 33'sd316933406;
            4'd2:    r = 33'sd167458907;
            4'd3:    r = 33'sd85004756;
            4'd4:    r = 33'sd42667331;
            4'd5:    r = 33'sd21354465;
            4'd6:    r = 33'sd10679838;
            4'd7:    r = 33'sd5340245;
            4'd8:    r = 33'sd2670163;
            4'd9:    r = 33'sd1335087;
            4'd10:   r = 33'sd667544;
            4'd11:   r = 33'sd333772;
            4'd12:   r = 33'sd166886;
            4'd13:   r = 33'sd83443;
            4'd14:   r = 33'sd41722;
            default: r = 33'sd20861;
         endcase
         return r;
      end
   endfunction

endpackage
`default_nettype wire

[rtl/wzfk_if.sv]
// interfaces: goal request channel and kinematics response channel
`timescale 1ns / 1ps
`default_nettype none
interface wzfk_req_if #(parameter int ANGLE_BITS = 16, parameter int LENGTH_BITS = 16);
   logic                          valid;
   logic                          ready;
   logic signed [ANGLE_BITS-1:0]  yaw_goal;
   logic signed [ANGLE_BITS-1:0]  pitch_goal;
   logic signed [ANGLE_BITS-1:0]  roll_goal;
   logic                          angles_valid;
   logic signed [LENGTH_BITS-1:0] tool_dx;
   logic signed [LENGTH_BITS-1:0] tool_dy;
   logic signed [LENGTH_BITS-1:0] tool_dz;
   modport source (output valid, yaw_goal, pitch_goal, roll_goal, angles_valid,
                   tool_dx, tool_dy, tool_dz, input ready);
   modport sink (input valid, yaw_goal, pitch_goal, roll_goal, angles_valid,
                 tool_dx, tool_dy, tool_dz, output ready);
endinterface

interface wzfk_rsp_if #(parameter int ANGLE_BITS = 16, parameter int LENGTH_BITS = 16);
   logic                            valid;
   logic                            ready;
   logic signed [ANGLE_BITS-1:0]    joint_yaw;
   logic signed [ANGLE_BITS-1:0]    joint_pitch;
   logic signed [ANGLE_BITS-1:0]    joint_roll;
   logic signed [LENGTH_BITS+2:0]   offset_x;
   logic signed [LENGTH_BITS+2:0]   offset_y;
   logic signed [LENGTH_BITS+2:0]   offset_z;
   modport source (output valid, joint_yaw, joint_pitch, joint_roll,
                   offset_x, offset_y, offset_z, input ready);
   modport sink (input valid, joint_yaw, joint_pitch, joint_roll,
                 offset_x, offset_y, offset_z, output ready);
endinterface
`default_nettype wire

[rtl/wzfk_ctrl.sv]
// controller: sequences cordic, multiply and writeback for the three rotations
`timescale 1ns / 1ps
`default_nettype none
module wzfk_ctrl
   import wzfk_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   output logic      req_ready,
   input  wire logic rsp_ready,
   output logic      rsp_valid,
   output cmd_type   cmd
);

   typedef enum logic [3:0] {
      S_IDLE, S_LOAD, S_ITER, S_TRIG, S_M0, S_M1, S_M2, S_M3, S_M4, S_DONE
   } state_type;

   state_type            state_ff, state_in;
   stage_type            stage_ff, stage_in;
   logic [STEP_BITS-1:0] step_ff, step_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      stage_in     = stage_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd.accept   = 1'b0;
      cmd.phase    = PH_IDLE;
      cmd.stage    = stage_ff;
      cmd.step     = step_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               stage_in   = STAGE_ROLL;
               state_in   = S_LOAD;
            end
         end
         S_LOAD: begin
            cmd.phase = PH_LOAD;
            step_in   = '0;
            state_in  = S_ITER;
         end
         S_ITER: begin
            cmd.phase = PH_ITER;
            step_in   = step_ff + 1'b1;
            if (step_ff == STEP_BITS'(CORDIC_STEPS - 1)) state_in = S_TRIG;
         end
         S_TRIG: begin
            cmd.phase = PH_TRIG;
            state_in  = S_M0;
         end
         S_M0: begin cmd.phase = PH_M0; state_in = S_M1; end
         S_M1: begin cmd.phase = PH_M1; state_in = S_M2; end
         S_M2: begin cmd.phase = PH_M2; state_in = S_M3; end
         S_M3: begin cmd.phase = PH_M3; state_in = S_M4; end
         S_M4: begin
            cmd.phase = PH_M4;
            case (stage_ff)
               STAGE_ROLL:  begin stage_in = STAGE_PITCH; state_in = S_LOAD; end
               STAGE_PITCH: begin stage_in = STAGE_YAW;   state_in = S_LOAD; end
               default:     state_in = S_DONE;
            endcase
         end
         S_DONE: begin
            if (out_free) begin
               cmd.phase    = PH_OUT;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         stage_ff     <= STAGE_ROLL;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         stage_ff     <= stage_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_accept_loads: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == S_LOAD && stage_ff == STAGE_ROLL))
      else $error("transfer did not start the roll stage");
   a_full_sweep: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_TRIG) |-> ($past(state_ff) == S_ITER &&
      $past(step_ff) == STEP_BITS'(CORDIC_STEPS - 1)))
      else $error("cordic left before its last step");
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (cmd.phase == PH_OUT) |-> out_free)
      else $error("result loaded over an untaken one");
   a_yaw_last: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE) |-> (stage_ff == STAGE_YAW))
      else $error("done before the yaw stage");

endmodule
`default_nettype wire

[rtl/wzfk_datapath.sv]
// datapath: held angles, link registers, cordic, shared multiplier, output register
`timescale 1ns / 1ps
`default_nettype none
module wzfk_datapath
   import wzfk_pkg::*;
#(
   parameter int ANGLE_BITS  = ANGLE_BITS_DEFAULT,
   parameter int LENGTH_BITS = LENGTH_BITS_DEFAULT
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire cmd_type                       cmd,
   input  wire logic signed [ANGLE_BITS-1:0]  yaw_goal,
   input  wire logic signed [ANGLE_BITS-1:0]  pitch_goal,
   input  wire logic signed [ANGLE_BITS-1:0]  roll_goal,
   input  wire logic                          angles_valid,
   input  wire logic signed [LENGTH_BITS-1:0] tool_dx,
   input  wire logic signed [LENGTH_BITS-1:0] tool_dy,
   input  wire logic signed [LENGTH_BITS-1:0] tool_dz,
   input  wire logic                          csr_we,
   input  wire logic [CSR_INDEX_BITS-1:0]     csr_index,
   input  wire logic [3*LENGTH_BITS-1:0]      csr_wdata,
   output logic signed [ANGLE_BITS-1:0]       joint_yaw,
   output logic signed [ANGLE_BITS-1:0]       joint_pitch,
   output logic signed [ANGLE_BITS-1:0]       joint_roll,
   output logic signed [LENGTH_BITS+2:0]      offset_x,
   output logic signed [LENGTH_BITS+2:0]      offset_y,
   output logic signed [LENGTH_BITS+2:0]      offset_z
);

   localparam int L  = LENGTH_BITS;
   localparam int W  = LENGTH_BITS + 4;
   localparam int OW = LENGTH_BITS + 3;
   localparam int PW = TRIG_BITS + W;
   localparam int AW = PW + 1;
   localparam int XW = CORDIC_BITS;
   localparam logic signed [W:0] OUT_HI = (W+1)'((1 << (OW - 1)) - 1);
   localparam logic signed [W:0] OUT_LO = -OUT_HI - (W+1)'(1);

   logic [3*L-1:0] base_link_ff, yaw_link_ff, pitch_link_ff;
   logic signed [ANGLE_BITS-1:0] held_yaw_ff, held_pitch_ff, held_roll_ff;
   logic signed [W-1:0] vx_ff, vy_ff, vz_ff, vx_in, vy_in, vz_in;
   logic signed [XW-1:0] x_ff, y_ff, z_ff;
   logic                 flip_ff;
   logic signed [TRIG_BITS-1:0] c_ff, s_ff;
   logic signed [PW-1:0] prod_ff, prod_in;
   logic signed [AW-1:0] acc_ff;
   logic signed [W-1:0]  ra_ff, rb;
   logic signed [TRIG_BITS-1:0] trig_sel;
   logic signed [W-1:0] coord_a, coord_b, coord_sel;
   logic signed [ANGLE_BITS-1:0] angle_sel;
   logic [PHASE_BITS-1:0] phase;
   logic [3*L-1:0] link_sel;
   logic signed [W-1:0] lx, ly, lz;
   logic signed [XW-1:0] xs, ys, x_rnd, y_rnd;
   logic signed [TRIG_BITS-1:0] c_rnd, s_rnd;
   logic signed [AW-1:0] sum_a, sum_b;
   logic signed [W:0] nx, ny, nz;

   function automatic logic signed [W-1:0] round_q15(input logic signed [AW-1:0] v);
      logic signed [AW-1:0] t;
      begin
         t = v + AW'(1 << 14);
         return t[W+14:15];
      end
   endfunction

   function automatic logic signed [OW-1:0] sat(input logic signed [W:0] v);
      logic signed [W:0] t;
      begin
         t = (v > OUT_HI) ? OUT_HI : ((v < OUT_LO) ? OUT_LO : v);
         return t[OW-1:0];
      end
   endfunction

   always_comb begin
      case (cmd.stage)
         STAGE_ROLL:  begin angle_sel = held_roll_ff;  link_sel = pitch_link_ff;
                            coord_a = vy_ff; coord_b = vz_ff; end
         STAGE_PITCH: begin angle_sel = held_pitch_ff; link_sel = yaw_link_ff;
                            coord_a = vz_ff; coord_b = vx_ff; end
         default:     begin angle_sel = held_yaw_ff;   link_sel = base_link_ff;
                            coord_a = vx_ff; coord_b = vy_ff; end
      endcase
   end

   assign lx = W'($signed(link_sel[L-1:0]));
   assign ly = W'($signed(link_sel[2*L-1:L]));
   assign lz = W'($signed(link_sel[3*L-1:2*L]));

   assign phase = {angle_sel, {(PHASE_BITS-ANGLE_BITS){1'b0}}};
   assign xs    = x_ff >>> cmd.step;
   assign ys    = y_ff >>> cmd.step;
   assign x_rnd = (x_ff + XW'(1 << 14)) >>> 15;
   assign y_rnd = (y_ff + XW'(1 << 14)) >>> 15;
   assign c_rnd = x_rnd[TRIG_BITS-1:0];
   assign s_rnd = y_rnd[TRIG_BITS-1:0];

   // product order: c*a, s*b, s*a, c*b
   always_comb begin
      case (cmd.phase)
         PH_M0:   begin trig_sel = c_ff; coord_sel = coord_a; end
         PH_M1:   begin trig_sel = s_ff; coord_sel = coord_b; end
         PH_M2:   begin trig_sel = s_ff; coord_sel = coord_a; end
         default: begin trig_sel = c_ff; coord_sel = coord_b; end
      endcase
   end
   assign prod_in = PW'(trig_sel) * PW'(coord_sel);

   assign sum_a = acc_ff - AW'(prod_ff);
   assign sum_b = acc_ff + AW'(prod_ff);
   assign rb    = round_q15(sum_b);

   always_comb begin
      vx_in = vx_ff;
      vy_in = vy_ff;
      vz_in = vz_ff;
      case (cmd.stage)
         STAGE_ROLL:  begin vx_in = vx_ff + lx; vy_in = ra_ff + ly; vz_in = rb + lz; end
         STAGE_PITCH: begin vx_in = rb + lx; vy_in = vy_ff + ly; vz_in = ra_ff + lz; end
         default:     begin vx_in = ra_ff + lx; vy_in = rb + ly; vz_in = vz_ff + lz; end
      endcase
   end

   assign nx = -(W+1)'(vx_ff);
   assign ny = -(W+1)'(vy_ff);
   assign nz = -(W+1)'(vz_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         base_link_ff  <= '0;
         yaw_link_ff   <= (3*L)'(YAW_LINK_RESET);
         pitch_link_ff <= '0;
         held_yaw_ff   <= '0;
         held_pitch_ff <= '0;
         held_roll_ff  <= '0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_BASE_LINK:  base_link_ff  <= csr_wdata;
               CSR_YAW_LINK:   yaw_link_ff   <= csr_wdata;
               CSR_PITCH_LINK: pitch_link_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (cmd.accept && angles_valid) begin
            held_yaw_ff   <= yaw_goal;
            held_pitch_ff <= pitch_goal;
            held_roll_ff  <= roll_goal;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         vx_ff <= W'(tool_dx);
         vy_ff <= W'(tool_dy);
         vz_ff <= W'(tool_dz);
      end
      case (cmd.phase)
         PH_LOAD: begin
            // second and third quadrant: turn by half a circle, negate later
            flip_ff <= phase[PHASE_BITS-1] ^ phase[PHASE_BITS-2];
            z_ff    <= XW'($signed({phase[PHASE_BITS-1] ^ phase[PHASE_BITS-2] ^
                                    phase[PHASE_BITS-1], phase[PHASE_BITS-2:0]}));
            x_ff    <= CORDIC_START;
            y_ff    <= '0;
         end
         PH_ITER: begin
            if (!z_ff[XW-1]) begin
               x_ff <= x_ff - ys;
               y_ff <= y_ff + xs;
               z_ff <= z_ff - atan_phase(cmd.step);
            end else begin
               x_ff <= x_ff + ys;
               y_ff <= y_ff - xs;
               z_ff <= z_ff + atan_phase(cmd.step);
            end
         end
         PH_TRIG: begin
            c_ff <= flip_ff ? -c_rnd : c_rnd;
            s_ff <= flip_ff ? -s_rnd : s_rnd;
         end
         PH_M0: prod_ff <= prod_in;
         PH_M1: begin acc_ff <= AW'(prod_ff); prod_ff <= prod_in; end
         PH_M2: begin ra_ff <= round_q15(sum_a); prod_ff <= prod_in; end
         PH_M3: begin acc_ff <= AW'(prod_ff); prod_ff <= prod_in; end
         PH_M4: begin vx_ff <= vx_in; vy_ff <= vy_in; vz_ff <= vz_in; end
         PH_OUT: begin
            joint_yaw   <= held_yaw_ff;
            joint_pitch <= held_pitch_ff;
            joint_roll  <= held_roll_ff;
            offset_x    <= sat(nx);
            offset_y    <= sat(ny);
            offset_z    <= sat(nz);
         end
         default: ;
      endcase
   end

endmodule
`default_nettype wire

[rtl/wrist_zyx_forward_kinematics_unit.sv]
// top level: zyx wrist forward kinematics with held joint angles
`timescale 1ns / 1ps
`default_nettype none
//  channel   | dir | payload
//  req_bus   | in  | yaw/pitch/roll goal, angles_valid, tool_dx/dy/dz
//  rsp_bus   | out | joint yaw/pitch/roll, offset_x/y/z
//  csr_*     | in  | write enable, index 0..2, packed x,y,z link vector
//
//  each item runs three rotations in turn, each made of a cordic load,
//  16 iterations, trig rounding and the M0..M4 steps on the one shared multiplier,
//  plus an accept step before and an output step after them
//  synchronous reset clears held angles, base and pitch links and control; yaw link resets to 393
//  a result waits in the output register while the next transfer is taken;
//  the controller waits at the end if that register is still full
module wrist_zyx_forward_kinematics_unit
   import wzfk_pkg::*;
#(
   parameter int ANGLE_BITS  = ANGLE_BITS_DEFAULT,
   parameter int LENGTH_BITS = LENGTH_BITS_DEFAULT
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   wzfk_req_if.sink                       req_bus,
   wzfk_rsp_if.source                     rsp_bus,
   input  wire logic                      csr_we,
   input  wire logic [CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [3*LENGTH_BITS-1:0]  csr_wdata
);

   cmd_type cmd;

   // sequencer: one item at a time, three rotations in turn
   wzfk_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_ready (rsp_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .cmd       (cmd)
   );

   // arithmetic and stored state
   wzfk_datapath #(
      .ANGLE_BITS  (ANGLE_BITS),
      .LENGTH_BITS (LENGTH_BITS)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .yaw_goal     (req_bus.yaw_goal),
      .pitch_goal   (req_bus.pitch_goal),
      .roll_goal    (req_bus.roll_goal),
      .angles_valid (req_bus.angles_valid),
      .tool_dx      (req_bus.tool_dx),
      .tool_dy      (req_bus.tool_dy),
      .tool_dz      (req_bus.tool_dz),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .joint_yaw    (rsp_bus.joint_yaw),
      .joint_pitch  (rsp_bus.joint_pitch),
      .joint_roll   (rsp_bus.joint_roll),
      .offset_x     (rsp_bus.offset_x),
      .offset_y     (rsp_bus.offset_y),
      .offset_z     (rsp_bus.offset_z)
   );

endmodule
`default_nettype wire
